>>> rtl/core/cda_pkg.sv
// cda_pkg: shared types, constants, microcode table and calendar helpers
// for the calendar date unit; no dependencies
`timescale 1ns / 1ps

package cda_pkg;

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// micro-operations driven into the datapath
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_MONTH_STEP,
		UOP_SET_OVF,
		UOP_ADD_FINAL,
		UOP_SERIAL_BASE,
		UOP_ACC_MONTH,
		UOP_LOAD_B,
		UOP_DIFF_FINAL,
		UOP_FINISH
	} uop_t;

	// branch conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_IS_DIFF,
		COND_FITS,
		COND_NO_OVF,
		COND_K_DONE,
		COND_PASS_B
	} cond_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} cword_t;

	typedef struct packed {
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
	} date_t;

	// program entry points
	localparam upc_t PC_DISPATCH  = 4'd0;
	localparam upc_t PC_ADD_TEST  = 4'd1;
	localparam upc_t PC_ADD_DONE  = 4'd4;
	localparam upc_t PC_SERIAL    = 4'd5;
	localparam upc_t PC_MON_TEST  = 4'd6;
	localparam upc_t PC_PASS_TEST = 4'd8;
	localparam upc_t PC_DIFF_FIN  = 4'd10;
	localparam upc_t PC_FINISH    = 4'd11;

	function automatic cword_t cda_rom(input upc_t pc);
		cword_t cw;
		case (pc)
			4'd0:    cw = '{UOP_NOP,         COND_IS_DIFF, PC_SERIAL};
			4'd1:    cw = '{UOP_NOP,         COND_FITS,    PC_ADD_DONE};
			4'd2:    cw = '{UOP_MONTH_STEP,  COND_NO_OVF,  PC_ADD_TEST};
			4'd3:    cw = '{UOP_SET_OVF,     COND_ALWAYS,  PC_FINISH};
			4'd4:    cw = '{UOP_ADD_FINAL,   COND_ALWAYS,  PC_FINISH};
			4'd5:    cw = '{UOP_SERIAL_BASE, COND_NEVER,   PC_DISPATCH};
			4'd6:    cw = '{UOP_NOP,         COND_K_DONE,  PC_PASS_TEST};
			4'd7:    cw = '{UOP_ACC_MONTH,   COND_ALWAYS,  PC_MON_TEST};
			4'd8:    cw = '{UOP_NOP,         COND_PASS_B,  PC_DIFF_FIN};
			4'd9:    cw = '{UOP_LOAD_B,      COND_ALWAYS,  PC_SERIAL};
			4'd10:   cw = '{UOP_DIFF_FINAL,  COND_NEVER,   PC_DISPATCH};
			default: cw = '{UOP_FINISH,      COND_NEVER,   PC_DISPATCH};
		endcase
		return cw;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic date_t clamp_date(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y);
		date_t      r;
		logic [4:0] len;
		r.m = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
		r.y = (y > YEAR_MAX) ? YEAR_MAX : y;
		len = month_len(r.m, r.y[1:0] == 2'b00);
		r.d = (d == 5'd0) ? 5'd1 : ((d > len) ? len : d);
		return r;
	endfunction

	function automatic logic [1:0] season_of(input logic [3:0] m);
		logic [1:0] s;
		case (m) inside
			4'd0, 4'd1, 4'd2, 4'd12: s = 2'd0;
			[4'd3 : 4'd5]:           s = 2'd1;
			[4'd6 : 4'd8]:           s = 2'd2;
			default:                 s = 2'd3;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/calendar_date_arithmetic.sv
// calendar_date_arithmetic: add days to a date, or count days between two dates
// depends on cda_pkg (microcode table, calendar helpers)
`timescale 1ns / 1ps

// One date operation at a time, run by a small microcoded sequencer. Leap years are
// every fourth year, year 0 included. An add steps over one month boundary at a time
// until the days left fit in the current month, then sets the final day, for counts
// of up to 65535 days, pinning the last date with overflow set past YEAR_MAX; a
// difference turns each date, A and then B, into a day number and subtracts. The next
// item is taken as soon as the sequencer has parked its result in the output register;
// a result waiting there only stalls the sequencer at its final step.
module calendar_date_arithmetic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [4:0]  day_a,
	input  logic [3:0]  month_a,
	input  logic [13:0] year_a,
	input  logic [15:0] day_count,
	input  logic [4:0]  day_b,
	input  logic [3:0]  month_b,
	input  logic [13:0] year_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  result_day,
	output logic [3:0]  result_month,
	output logic [13:0] result_year,
	output logic [21:0] day_difference,
	output logic [1:0]  season,
	output logic        year_overflow
);
	import cda_pkg::*;

	logic        busy_q;
	upc_t        pc_q;
	logic        out_valid_q;

	logic        op_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [15:0] n_q;
	date_t       b_q;
	logic [21:0] acc_q;
	logic [21:0] sa_q;
	logic [3:0]  k_q;
	logic        pass_q;
	logic        ovf_q;
	logic [1:0]  season_q;

	logic [4:0]  res_day_q;
	logic [3:0]  res_month_q;
	logic [13:0] res_year_q;
	logic [21:0] res_diff_q;
	logic [1:0]  res_season_q;
	logic        res_ovf_q;

	cword_t      cw;
	logic        in_xfer;
	logic        stall;
	logic        take;
	logic [4:0]  cur_len;
	logic [4:0]  k_len;
	logic [16:0] fit_sum;
	logic [21:0] base;
	date_t       a_cl;
	date_t       b_cl;

	assign in_ready  = !busy_q;
	assign in_xfer   = in_valid && in_ready;
	assign cw        = cda_rom(pc_q);
	// final step waits for the output register to free up
	assign stall     = (cw.uop == UOP_FINISH) && out_valid_q && !out_ready;

	assign a_cl      = clamp_date(day_a, month_a, year_a);
	assign b_cl      = clamp_date(day_b, month_b, year_b);
	assign cur_len   = month_len(m_q, y_q[1:0] == 2'b00);
	assign k_len     = month_len(k_q, y_q[1:0] == 2'b00);
	assign fit_sum   = 17'(d_q) + 17'(n_q);
	// 365*y + ceil(y/4) + d
	assign base      = 22'(y_q) * 22'd365 + 22'(y_q[13:2]) + 22'(|y_q[1:0]) + 22'(d_q);

	always_comb begin
		case (cw.cond)
			COND_NEVER:   take = 1'b0;
			COND_ALWAYS:  take = 1'b1;
			COND_IS_DIFF: take = op_q;
			COND_FITS:    take = fit_sum <= 17'(cur_len);
			COND_NO_OVF:  take = !(m_q == 4'd12 && y_q == YEAR_MAX);
			COND_K_DONE:  take = k_q >= m_q;
			COND_PASS_B:  take = pass_q;
			default:      take = 1'b0;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_DISPATCH;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
				pc_q   <= PC_DISPATCH;
			end else if (busy_q && !stall) begin
				if (cw.uop == UOP_FINISH)
					busy_q <= 1'b0;
				pc_q <= take ? cw.target : pc_q + 4'd1;
			end
			if (busy_q && !stall && cw.uop == UOP_FINISH)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= opcode;
			d_q      <= a_cl.d;
			m_q      <= a_cl.m;
			y_q      <= a_cl.y;
			n_q      <= day_count;
			b_q      <= b_cl;
			season_q <= season_of(month_a);
			ovf_q    <= 1'b0;
			pass_q   <= 1'b0;
		end else if (busy_q && !stall) begin
			case (cw.uop)
				UOP_MONTH_STEP: begin
					n_q <= n_q - 16'(cur_len - d_q);
					d_q <= 5'd0;
					if (m_q == 4'd12) begin
						m_q <= 4'd1;
						y_q <= y_q + 14'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
				UOP_SET_OVF: begin
					d_q   <= 5'd31;
					m_q   <= 4'd12;
					y_q   <= YEAR_MAX;
					ovf_q <= 1'b1;
				end
				UOP_ADD_FINAL: begin
					d_q <= fit_sum[4:0];
				end
				UOP_SERIAL_BASE: begin
					acc_q <= base;
					k_q   <= 4'd1;
				end
				UOP_ACC_MONTH: begin
					acc_q <= acc_q + 22'(k_len);
					k_q   <= k_q + 4'd1;
				end
				UOP_LOAD_B: begin
					sa_q   <= acc_q;
					d_q    <= b_q.d;
					m_q    <= b_q.m;
					y_q    <= b_q.y;
					pass_q <= 1'b1;
				end
				UOP_DIFF_FINAL: begin
					acc_q <= (acc_q > sa_q) ? acc_q - sa_q : 22'd0;
				end
				UOP_FINISH: begin
					res_season_q <= season_q;
					if (op_q) begin
						res_day_q   <= 5'd0;
						res_month_q <= 4'd0;
						res_year_q  <= 14'd0;
						res_ovf_q   <= 1'b0;
						res_diff_q  <= acc_q;
					end else begin
						res_day_q   <= d_q;
						res_month_q <= m_q;
						res_year_q  <= y_q;
						res_ovf_q   <= ovf_q;
						res_diff_q  <= 22'd0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_day     = res_day_q;
	assign result_month   = res_month_q;
	assign result_year    = res_year_q;
	assign day_difference = res_diff_q;
	assign season         = res_season_q;
	assign year_overflow  = res_ovf_q;

endmodule

>>> rtl/core/cda_check.sv
// cda_check: port-level assertions for calendar_date_arithmetic, bound to the top level
// depends on cda_pkg (YEAR_MAX)
`timescale 1ns / 1ps

module cda_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  result_day,
	input logic [3:0]  result_month,
	input logic [13:0] result_year,
	input logic [21:0] day_difference,
	input logic [1:0]  season,
	input logic        year_overflow
);
	import cda_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_day)
		&& $stable(result_month) && $stable(result_year)
		&& $stable(day_difference) && $stable(season) && $stable(year_overflow))
		else $error("result changed while stalled");

	// one item at a time: a transfer in closes the input side
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_ovf_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && year_overflow |-> result_day == 5'd31 && result_month == 4'd12
		&& result_year == YEAR_MAX && day_difference == 22'd0)
		else $error("overflow result not pinned to last date");

	a_diff_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && day_difference != 22'd0 |-> result_day == 5'd0
		&& result_month == 4'd0 && result_year == 14'd0 && !year_overflow)
		else $error("difference result carries date fields");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_year <= YEAR_MAX)
		else $error("result year out of range");

endmodule

bind calendar_date_arithmetic cda_check u_cda_check (.*);

>>> tb/sv/calendar_date_arithmetic_test.sv
// calendar_date_arithmetic_test: self-checking bench for the date add / day difference unit
// drives requests from a queue, predicts each result in-bench and compares it per field
// depends on cda_pkg and calendar_date_arithmetic
`timescale 1ns / 1ps

module calendar_date_arithmetic_test;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_DIFF = 1'b1;

	localparam logic [1:0] SEASON_WINTER = 2'd0;
	localparam logic [1:0] SEASON_SPRING = 2'd1;
	localparam logic [1:0] SEASON_SUMMER = 2'd2;
	localparam logic [1:0] SEASON_AUTUMN = 2'd3;

	localparam int LAST_YEAR     = int'(cda_pkg::YEAR_MAX);
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int IDLE_PERCENT  = 18;
	localparam int HOLD_CYCLES   = 5000;
	localparam int SHOWN_ERRORS  = 10;

	typedef struct packed {
		logic        op;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [13:0] year_a;
		logic [15:0] count;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [13:0] year_b;
	} date_request_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [21:0] diff;
		logic [1:0]  season;
		logic        ovf;
	} date_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        opcode    = OP_ADD;
	logic [4:0]  day_a     = '0;
	logic [3:0]  month_a   = '0;
	logic [13:0] year_a    = '0;
	logic [15:0] day_count = '0;
	logic [4:0]  day_b     = '0;
	logic [3:0]  month_b   = '0;
	logic [13:0] year_b    = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  result_day;
	logic [3:0]  result_month;
	logic [13:0] result_year;
	logic [21:0] day_difference;
	logic [1:0]  season;
	logic        year_overflow;

	date_request_t pending_requests[$];
	date_result_t  expected_results[$];

	logic in_taken = 1'b0;
	int   requests_taken = 0;
	int   results_seen = 0;
	int   error_count = 0;
	int   add_count = 0;
	int   ovf_count = 0;
	int   diff_count = 0;
	int   nonzero_diff_count = 0;
	int   cycle_count = 0;
	int   hold_left = 0;
	bit   hold_done = 0;

	// stretch of requests with no idling on either side
	wire calm = requests_taken >= 55 && requests_taken < 80;

	calendar_date_arithmetic dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.day_a(day_a),
		.month_a(month_a),
		.year_a(year_a),
		.day_count(day_count),
		.day_b(day_b),
		.month_b(month_b),
		.year_b(year_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_day(result_day),
		.result_month(result_month),
		.result_year(result_year),
		.day_difference(day_difference),
		.season(season),
		.year_overflow(year_overflow)
	);

	always #5 clk = ~clk;

	function automatic int days_in_month(input int m, input int y);
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		if (m == 2)
			return (y % 4 == 0) ? 29 : 28;
		return 31;
	endfunction

	// pull month, year and day back into the calendar
	function automatic void settle_date(input int d, input int m, input int y,
			output int od, output int om, output int oy);
		om = (m == 0) ? 1 : ((m > 12) ? 12 : m);
		oy = (y > LAST_YEAR) ? LAST_YEAR : y;
		od = (d == 0) ? 1 : d;
		if (od > days_in_month(om, oy))
			od = days_in_month(om, oy);
	endfunction

	function automatic int day_number(input int d, input int m, input int y);
		int total;
		total = 365 * y + (y + 3) / 4 + d;
		for (int k = 1; k < m; k++)
			total += days_in_month(k, y);
		return total;
	endfunction

	function automatic date_result_t date_op_result(input date_request_t req);
		date_result_t r;
		int da, ma, ya, db, mb, yb, left, na, nb;
		r = '0;
		settle_date(req.day_a, req.month_a, req.year_a, da, ma, ya);
		if (req.op == OP_ADD) begin
			left = req.count;
			while (!r.ovf && da + left > days_in_month(ma, ya)) begin
				left -= days_in_month(ma, ya) - da;
				da = 0;
				ma++;
				if (ma == 13) begin
					ma = 1;
					ya++;
					if (ya > LAST_YEAR)
						r.ovf = 1'b1;
				end
			end
			if (r.ovf) begin
				r.day   = 5'd31;
				r.month = 4'd12;
				r.year  = cda_pkg::YEAR_MAX;
			end else begin
				r.day   = 5'(da + left);
				r.month = 4'(ma);
				r.year  = 14'(ya);
			end
		end else begin
			settle_date(req.day_b, req.month_b, req.year_b, db, mb, yb);
			na = day_number(da, ma, ya);
			nb = day_number(db, mb, yb);
			if (nb > na)
				r.diff = 22'(nb - na);
		end
		// season follows the raw month, out-of-range codes included
		case (req.month_a)
			4'd3, 4'd4, 4'd5:                           r.season = SEASON_SPRING;
			4'd6, 4'd7, 4'd8:                           r.season = SEASON_SUMMER;
			4'd9, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15:    r.season = SEASON_AUTUMN;
			default:                                    r.season = SEASON_WINTER;
		endcase
		return r;
	endfunction

	task automatic queue_item(input logic op, input int da, input int ma, input int ya,
			input int cnt, input int db, input int mb, input int yb);
		date_request_t req;
		req.op      = op;
		req.day_a   = 5'(da);
		req.month_a = 4'(ma);
		req.year_a  = 14'(ya);
		req.count   = 16'(cnt);
		req.day_b   = 5'(db);
		req.month_b = 4'(mb);
		req.year_b  = 14'(yb);
		pending_requests.push_back(req);
	endtask

	// request driver
	always @(negedge clk) begin : drive_requests
		date_request_t offer;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_requests.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					offer = pending_requests.pop_front();
					opcode    <= offer.op;
					day_a     <= offer.day_a;
					month_a   <= offer.month_a;
					year_a    <= offer.year_a;
					day_count <= offer.count;
					day_b     <= offer.day_b;
					month_b   <= offer.month_b;
					year_b    <= offer.year_b;
					in_valid  <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= 20) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin : watch_transfers
		date_result_t got, want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_results.push_back(date_op_result({opcode, day_a, month_a, year_a,
						day_count, day_b, month_b, year_b}));
				requests_taken++;
			end
			if (out_valid && out_ready) begin
				got = {result_day, result_month, result_year, day_difference, season,
						year_overflow};
				results_seen++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= SHOWN_ERRORS)
						$display("result %0d arrived with nothing outstanding", results_seen);
				end else begin
					want = expected_results.pop_front();
					if (want.diff != 0)
						nonzero_diff_count++;
					if (want.ovf)
						ovf_count++;
					if (got.day !== want.day || got.month !== want.month ||
							got.year !== want.year || got.diff !== want.diff ||
							got.season !== want.season || got.ovf !== want.ovf) begin
						error_count++;
						if (error_count <= SHOWN_ERRORS) begin
							$display("result %0d mismatch: expected %0d.%0d.%0d diff %0d %s",
									results_seen, want.day, want.month, want.year,
									want.diff, "season/ovf below");
							$display("  expected season %0d ovf %0d", want.season,
									want.ovf);
							$display("  got %0d.%0d.%0d diff %0d season %0d ovf %0d",
									got.day, got.month, got.year, got.diff, got.season,
									got.ovf);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
					expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		date_request_t req;
		int pick;

		// directed: field extremes, leap days, clamping, overflow, odd season codes
		queue_item(OP_ADD, 1, 1, 0, 0, 0, 0, 0);
		queue_item(OP_ADD, 31, 12, 9999, 65535, 31, 15, 16383);
		queue_item(OP_ADD, 31, 12, 9998, 1, 1, 1, 0);
		queue_item(OP_ADD, 31, 12, 9999, 1, 1, 1, 0);
		queue_item(OP_ADD, 1, 1, 9999, 364, 1, 1, 0);
		queue_item(OP_ADD, 1, 1, 9999, 365, 1, 1, 0);
		queue_item(OP_ADD, 28, 2, 2024, 1, 1, 1, 0);
		queue_item(OP_ADD, 28, 2, 2023, 1, 1, 1, 0);
		queue_item(OP_ADD, 0, 0, 0, 59, 0, 0, 0);
		queue_item(OP_ADD, 31, 2, 2023, 0, 1, 1, 0);
		queue_item(OP_ADD, 15, 15, 16383, 0, 1, 1, 0);
		queue_item(OP_ADD, 31, 13, 100, 400, 1, 1, 0);
		queue_item(OP_ADD, 10, 14, 5, 65535, 1, 1, 0);
		queue_item(OP_ADD, 1, 1, 0, 65535, 1, 1, 0);
		queue_item(OP_DIFF, 1, 1, 0, 0, 31, 12, 9999);
		queue_item(OP_DIFF, 17, 7, 1999, 0, 17, 7, 1999);
		queue_item(OP_DIFF, 2, 3, 2020, 0, 1, 3, 2020);
		queue_item(OP_DIFF, 1, 3, 2023, 0, 1, 3, 2024);
		queue_item(OP_DIFF, 0, 0, 16383, 0, 31, 15, 16383);
		queue_item(OP_DIFF, 5, 6, 2000, 0, 5, 9, 2000);
		queue_item(OP_DIFF, 31, 15, 16383, 65535, 31, 15, 16383);
		queue_item(OP_DIFF, 31, 12, 2019, 0, 31, 2, 2020);

		// random: mostly calendar-valid dates, some raw noise, B usually after A
		for (int n = 0; n < 78; n++) begin
			req.op = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < 15) begin
				req.day_a   = 5'($urandom_range(0, 31));
				req.month_a = 4'($urandom_range(0, 15));
				req.year_a  = 14'($urandom_range(0, 16383));
			end else begin
				req.day_a   = 5'($urandom_range(1, 31));
				req.month_a = 4'($urandom_range(1, 12));
				req.year_a  = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(9980, 9999))
						: 14'($urandom_range(0, 9999));
			end
			pick = int'($urandom_range(0, 99));
			if (pick < 60)
				req.count = 16'($urandom_range(0, 800));
			else if (pick < 85)
				req.count = 16'($urandom_range(0, 10000));
			else
				req.count = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 99) < 70) begin
				req.day_b   = 5'($urandom_range(1, 31));
				req.month_b = 4'($urandom_range(1, 12));
				req.year_b  = req.year_a + 14'($urandom_range(0, 40));
			end else begin
				req.day_b   = 5'($urandom_range(0, 31));
				req.month_b = 4'($urandom_range(0, 15));
				req.year_b  = 14'($urandom_range(0, 16383));
			end
			if (req.op == OP_ADD)
				add_count++;
			else
				diff_count++;
			pending_requests.push_back(req);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d requests through, %0d results checked in %0d cycles", requests_taken,
				results_seen, cycle_count);
		$display("random mix: %0d adds, %0d differences; %0d year overflows, %0d nonzero gaps",
				add_count, diff_count, ovf_count, nonzero_diff_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
